FILE: rtl/core/tra_pkg.sv
package tra_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 16;
  localparam int unsigned ID_W          = 15;
  localparam int unsigned TIME_W        = 64;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SLOT_OUT_W    = 4;
  localparam int unsigned COUNT_OUT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_SWITCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_PARTIAL   = 2'd3
  } status_e;

  // one table slot as kept in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] start;
  } slot_rec_t;

endpackage

FILE: rtl/core/tra_if.sv
interface tra_in_if;
  logic                                valid;
  logic                                ready;
  logic [tra_pkg::CMD_W-1:0]           cmd;
  logic [tra_pkg::ID_W-1:0]            task_id;
  logic [tra_pkg::ID_W-1:0]            next_task_id;
  logic [tra_pkg::TIME_W-1:0]          timestamp;

  modport source (output valid, cmd, task_id, next_task_id, timestamp, input ready);
  modport sink   (input valid, cmd, task_id, next_task_id, timestamp, output ready);
endinterface

interface tra_out_if;
  logic                                valid;
  logic                                ready;
  logic [tra_pkg::STATUS_W-1:0]        status;
  logic [tra_pkg::SLOT_OUT_W-1:0]      slot_index;
  logic [tra_pkg::TIME_W-1:0]          charged_runtime;
  logic [tra_pkg::COUNT_OUT_W-1:0]     active_count;

  modport source (output valid, status, slot_index, charged_runtime, active_count,
                  input ready);
  modport sink   (input valid, status, slot_index, charged_runtime, active_count,
                  output ready);
endinterface

FILE: rtl/core/tra_slot_mem.sv
module tra_slot_mem #(
  parameter int unsigned MAX_SLOTS = tra_pkg::MAX_SLOTS_DEF,
  localparam int unsigned IW = $clog2(MAX_SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IW-1:0]       waddr_i,
  input  tra_pkg::slot_rec_t  wdata_i,
  input  logic                re_i,
  input  logic [IW-1:0]       raddr_i,
  output tra_pkg::slot_rec_t  rdata_o
);

  tra_pkg::slot_rec_t mem_q [MAX_SLOTS];
  tra_pkg::slot_rec_t rdata_q;
  logic [MAX_SLOTS-1:0] wr_q;
  logic [IW+tra_pkg::ID_W-1:0] addr_ext;
  tra_pkg::slot_rec_t rst_rec;

  // an entry never written reads as its reset record: id = slot number
  assign addr_ext = {{tra_pkg::ID_W{1'b0}}, raddr_i};
  always_comb begin
    rst_rec       = '0;
    rst_rec.id    = addr_ext[tra_pkg::ID_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
    end else if (we_i) begin
      wr_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= wr_q[raddr_i] ? mem_q[raddr_i] : rst_rec;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tra_adder.sv
module tra_adder (
  input  logic [tra_pkg::TIME_W-1:0] a_i,
  input  logic [tra_pkg::TIME_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [tra_pkg::TIME_W-1:0] sum_o
);

  logic [tra_pkg::TIME_W-1:0] b_eff;

  assign b_eff = b_i ^ {tra_pkg::TIME_W{sub_i}};
  assign sum_o = a_i + b_eff + {{(tra_pkg::TIME_W-1){1'b0}}, sub_i};

endmodule

FILE: rtl/core/task_runtime_accounting_table_top.sv
// Channel   Dir  Beat contents
// in_i      in   cmd, task_id, next_task_id, timestamp
// out_o     out  status, slot_index, charged_runtime, active_count
//
// Each slot scanned is read, then evaluated; each charged slot (at most two) takes
// an extra add step for the second pass through the shared 64-bit adder. A command
// scans up to MAX_SLOTS slots; an unused command skips the scan.
// in_i is ready only while the sequencer is idle; one result can wait in the
// output register while the next command is taken.
// Reset marks slots 0 and 1 valid with ids 0 and 1; no clearing pass is needed.
module task_runtime_accounting_table_top #(
  parameter int unsigned MAX_SLOTS = tra_pkg::MAX_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tra_in_if.sink     in_i,
  tra_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ADD,
    S_DONE
  } state_e;

  state_e                      state_q;
  tra_pkg::cmd_e               cmd_q;
  logic [tra_pkg::ID_W-1:0]    id_q;
  logic [tra_pkg::ID_W-1:0]    next_q;
  logic [tra_pkg::TIME_W-1:0]  now_q;
  logic [IW-1:0]               idx_q;
  logic [1:0]                  found_q;
  logic                        charged_any_q;
  logic [tra_pkg::TIME_W-1:0]  acc_q;
  logic [IW-1:0]               res_slot_q;
  logic [tra_pkg::TIME_W-1:0]  res_charged_q;
  tra_pkg::status_e            res_status_q;
  logic [CW-1:0]               cnt_q;
  logic [MAX_SLOTS-1:0]        valid_q;

  logic                        out_valid_q;
  tra_pkg::status_e            out_status_q;
  logic [tra_pkg::SLOT_OUT_W-1:0]  out_slot_q;
  logic [tra_pkg::TIME_W-1:0]  out_charged_q;
  logic [tra_pkg::COUNT_OUT_W-1:0] out_count_q;

  tra_pkg::slot_rec_t          rec;
  tra_pkg::slot_rec_t          wdata;
  logic                        we;
  logic                        v_cur;
  logic                        id_hit;
  logic                        nx_hit;
  logic                        last;
  logic [1:0]                  found_p1;
  logic [tra_pkg::TIME_W-1:0]  alu_a;
  logic [tra_pkg::TIME_W-1:0]  alu_b;
  logic                        alu_sub;
  logic [tra_pkg::TIME_W-1:0]  alu_sum;
  logic [IW+tra_pkg::SLOT_OUT_W-1:0]  slot_ext;
  logic [CW+tra_pkg::COUNT_OUT_W-1:0] cnt_ext;

  tra_slot_mem #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (state_q == S_READ),
    .raddr_i (idx_q),
    .rdata_o (rec)
  );

  tra_adder u_add (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign v_cur    = valid_q[idx_q];
  assign id_hit   = v_cur && (rec.id == id_q);
  assign nx_hit   = v_cur && (rec.id == next_q);
  assign last     = (idx_q == IW'(MAX_SLOTS - 1));
  assign found_p1 = found_q + 2'd1;

  // evaluate: elapsed = now - stamp; add: total + elapsed
  always_comb begin
    if (state_q == S_EVAL) begin
      alu_a   = now_q;
      alu_b   = rec.start;
      alu_sub = 1'b1;
    end else begin
      alu_a   = rec.total;
      alu_b   = acc_q;
      alu_sub = 1'b0;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (state_q == S_EVAL) begin
      unique case (cmd_q)
        tra_pkg::CMD_START: begin
          if (!v_cur) begin
            we       = 1'b1;
            wdata.id = id_q;
          end
        end
        tra_pkg::CMD_STOP: begin
          we = id_hit;
        end
        tra_pkg::CMD_SWITCH: begin
          if (!id_hit && nx_hit) begin
            we          = 1'b1;
            wdata       = rec;
            wdata.start = now_q;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_ADD) begin
      we          = 1'b1;
      wdata       = rec;
      wdata.total = alu_sum;
    end
  end

  function automatic tra_pkg::status_e sw_status(input logic [1:0] found);
    tra_pkg::status_e s;
    unique case (found)
      2'd2:    s = tra_pkg::STS_OK;
      2'd1:    s = tra_pkg::STS_PARTIAL;
      default: s = tra_pkg::STS_NOT_FOUND;
    endcase
    return s;
  endfunction

  assign slot_ext = {{tra_pkg::SLOT_OUT_W{1'b0}}, res_slot_q};
  assign cnt_ext  = {{tra_pkg::COUNT_OUT_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      cnt_q         <= CW'(2);
      valid_q       <= MAX_SLOTS'(3);
      cmd_q         <= tra_pkg::CMD_NONE;
      id_q          <= '0;
      next_q        <= '0;
      now_q         <= '0;
      idx_q         <= '0;
      found_q       <= '0;
      charged_any_q <= 1'b0;
      acc_q         <= '0;
      res_slot_q    <= '0;
      res_charged_q <= '0;
      res_status_q  <= tra_pkg::STS_OK;
      out_status_q  <= tra_pkg::STS_OK;
      out_slot_q    <= '0;
      out_charged_q <= '0;
      out_count_q   <= '0;
    end else begin
      // in S_DONE the output register is handled below
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q         <= tra_pkg::cmd_e'(in_i.cmd);
            id_q          <= in_i.task_id;
            next_q        <= in_i.next_task_id;
            now_q         <= in_i.timestamp;
            found_q       <= '0;
            charged_any_q <= 1'b0;
            res_slot_q    <= '0;
            res_charged_q <= '0;
            res_status_q  <= tra_pkg::STS_OK;
            // switch scans from the idle slot, start/stop from slot 1
            idx_q <= (tra_pkg::cmd_e'(in_i.cmd) == tra_pkg::CMD_SWITCH) ? '0 : IW'(1);
            state_q <= (tra_pkg::cmd_e'(in_i.cmd) == tra_pkg::CMD_NONE) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          unique case (cmd_q)
            tra_pkg::CMD_START: begin
              if (!v_cur) begin
                valid_q[idx_q] <= 1'b1;
                cnt_q          <= cnt_q + CW'(1);
                res_slot_q     <= idx_q;
                state_q        <= S_DONE;
              end else if (last) begin
                res_status_q <= tra_pkg::STS_FULL;
                state_q      <= S_DONE;
              end else begin
                idx_q   <= idx_q + IW'(1);
                state_q <= S_READ;
              end
            end
            tra_pkg::CMD_STOP: begin
              if (id_hit) begin
                valid_q[idx_q] <= 1'b0;
                cnt_q          <= cnt_q - CW'(1);
                res_slot_q     <= idx_q;
                state_q        <= S_DONE;
              end else if (last) begin
                res_status_q <= tra_pkg::STS_NOT_FOUND;
                state_q      <= S_DONE;
              end else begin
                idx_q   <= idx_q + IW'(1);
                state_q <= S_READ;
              end
            end
            tra_pkg::CMD_SWITCH: begin
              if (id_hit) begin
                acc_q   <= alu_sum;
                state_q <= S_ADD;
              end else if (nx_hit) begin
                found_q <= found_p1;
                if (found_p1 == 2'd2 || last) begin
                  res_status_q <= sw_status(found_p1);
                  state_q      <= S_DONE;
                end else begin
                  idx_q   <= idx_q + IW'(1);
                  state_q <= S_READ;
                end
              end else if (last) begin
                res_status_q <= sw_status(found_q);
                state_q      <= S_DONE;
              end else begin
                idx_q   <= idx_q + IW'(1);
                state_q <= S_READ;
              end
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_ADD: begin
          found_q <= found_p1;
          if (!charged_any_q) begin
            charged_any_q <= 1'b1;
            res_slot_q    <= idx_q;
            res_charged_q <= alu_sum;
          end
          if (found_p1 == 2'd2 || last) begin
            res_status_q <= sw_status(found_p1);
            state_q      <= S_DONE;
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status_q;
            out_slot_q    <= slot_ext[tra_pkg::SLOT_OUT_W-1:0];
            out_charged_q <= res_charged_q;
            out_count_q   <= cnt_ext[tra_pkg::COUNT_OUT_W-1:0];
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.slot_index      = out_slot_q;
  assign out_o.charged_runtime = out_charged_q;
  assign out_o.active_count    = out_count_q;

endmodule

FILE: tb/tb_acct_checker.sv
// Watches both channels of the accounting table, keeps its own copy of the
// slot table and compares every output beat against the oldest predicted one.
module tb_acct_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tra_in_if    in_mon,
  tra_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tra_pkg::*;

  localparam int unsigned NSLOT = MAX_SLOTS_DEF;

  typedef struct {
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [TIME_W-1:0]      charged;
    logic [COUNT_OUT_W-1:0] count;
  } acct_outcome_t;

  slot_rec_t     tbl  [NSLOT];
  bit            live [NSLOT];
  int            live_cnt;
  acct_outcome_t outcome_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic void clear_table();
    int s;
    for (s = 0; s < NSLOT; s++) begin
      live[s]      = 1'b0;
      tbl[s].id    = ID_W'(s);
      tbl[s].total = '0;
      tbl[s].start = '0;
    end
    live[0]  = 1'b1;
    live[1]  = 1'b1;
    live_cnt = 2;
  endfunction

  // Applies one command to the shadow table and returns what the block owes.
  function automatic acct_outcome_t account_cmd(input logic [CMD_W-1:0]  cmd,
                                                input logic [ID_W-1:0]   id,
                                                input logic [ID_W-1:0]   nid,
                                                input logic [TIME_W-1:0] ts);
    acct_outcome_t o;
    int            s;
    int            found;
    bit            charged_any;
    o.status    = STS_OK;
    o.slot      = '0;
    o.charged   = '0;
    found       = 0;
    charged_any = 1'b0;
    case (cmd)
      CMD_START: begin
        o.status = STS_FULL;
        for (s = 1; s < NSLOT; s++) begin
          if (!live[s]) begin
            live[s]      = 1'b1;
            tbl[s].id    = id;
            tbl[s].total = '0;
            tbl[s].start = '0;
            live_cnt++;
            o.status = STS_OK;
            o.slot   = SLOT_OUT_W'(s);
            break;
          end
        end
      end
      CMD_STOP: begin
        o.status = STS_NOT_FOUND;
        // slot 0 is the idle task and never freed
        for (s = 1; s < NSLOT; s++) begin
          if (live[s] && tbl[s].id == id) begin
            live[s]      = 1'b0;
            tbl[s].id    = '0;
            tbl[s].total = '0;
            tbl[s].start = '0;
            live_cnt--;
            o.status = STS_OK;
            o.slot   = SLOT_OUT_W'(s);
            break;
          end
        end
      end
      CMD_SWITCH: begin
        for (s = 0; s < NSLOT; s++) begin
          if (live[s]) begin
            if (tbl[s].id == id) begin
              tbl[s].total = tbl[s].total + (ts - tbl[s].start);
              if (!charged_any) begin
                charged_any = 1'b1;
                o.slot      = SLOT_OUT_W'(s);
                o.charged   = tbl[s].total;
              end
              found++;
            end else if (tbl[s].id == nid) begin
              tbl[s].start = ts;
              found++;
            end
          end
          if (found == 2) break;
        end
        o.status = (found == 2) ? STS_OK : ((found == 1) ? STS_PARTIAL : STS_NOT_FOUND);
      end
      default: ;
    endcase
    o.count = COUNT_OUT_W'(live_cnt);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    acct_outcome_t want;
    if (!rst_ni) begin
      clear_table();
      outcome_q.delete();
    end else begin
      // output first: a result never belongs to the beat taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("output beat with nothing outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, want.status));
          if (out_mon.slot_index !== want.slot)
            report_mismatch($sformatf("slot_index got %0d want %0d",
                                      out_mon.slot_index, want.slot));
          if (out_mon.charged_runtime !== want.charged)
            report_mismatch($sformatf("charged_runtime got %0h want %0h",
                                      out_mon.charged_runtime, want.charged));
          if (out_mon.active_count !== want.count)
            report_mismatch($sformatf("active_count got %0d want %0d",
                                      out_mon.active_count, want.count));
        end
      end
      if (in_mon.valid && in_mon.ready)
        outcome_q.push_back(account_cmd(in_mon.cmd, in_mon.task_id,
                                        in_mon.next_task_id, in_mon.timestamp));
    end
    pending_o = outcome_q.size();
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tra_pkg::*;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 80;

  logic clk;
  logic rst_n;

  tra_in_if  in_ch();
  tra_out_if out_ch();

  int fail_count;
  int pending;

  int send_idle;
  int recv_stall;
  int hold_reqs;

  logic [TIME_W-1:0] now;

  task_runtime_accounting_table_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tb_acct_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("task_runtime_accounting_table_top regression: fail");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_seen;
    int n;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Called on a rising edge; returns on the edge that took the beat.
  task automatic send_beat(input cmd_e c, input logic [ID_W-1:0] id,
                           input logic [ID_W-1:0] nid, input logic [TIME_W-1:0] ts);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.task_id      <= id;
    in_ch.next_task_id <= nid;
    in_ch.timestamp    <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly a small pool so ids collide and match; sometimes any id.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return ID_W'($urandom_range(0, 5));
    return ID_W'($urandom_range(0, 32767));
  endfunction

  task automatic random_beat(input int start_w, input int stop_w);
    int   r;
    cmd_e c;
    r = $urandom_range(99);
    if (r < start_w)               c = CMD_START;
    else if (r < start_w + stop_w) c = CMD_STOP;
    else if (r < 96)               c = CMD_SWITCH;
    else                           c = CMD_NONE;
    if ($urandom_range(99) < 3) now = {$urandom, $urandom};
    else                        now = now + TIME_W'($urandom_range(1, 5000));
    send_beat(c, pick_id(), pick_id(), now);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input int start_w, input int stop_w, input bit squeeze);
    int i;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    for (i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (squeeze && i == ITEMS_PER_PHASE / 2) hold_reqs++;
      random_beat(start_w, stop_w);
    end
  endtask

  initial begin
    hold_reqs  = 0;
    send_idle  = 0;
    recv_stall = 0;
    now        = '0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_NONE;
    in_ch.task_id      <= '0;
    in_ch.next_task_id <= '0;
    in_ch.timestamp    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle/task 1 handover, equal ids, partial and empty matches
    send_beat(CMD_SWITCH, 15'd0, 15'd1, 64'd100);
    send_beat(CMD_SWITCH, 15'd1, 15'd0, 64'd350);
    send_beat(CMD_SWITCH, 15'd1, 15'd1, 64'd400);
    send_beat(CMD_SWITCH, 15'd7, 15'd0, 64'd500);
    send_beat(CMD_SWITCH, 15'd9, 15'd8, 64'd550);
    send_beat(CMD_START,  15'h7fff, 15'd0, 64'd600);
    send_beat(CMD_START,  15'd1, 15'h7fff, 64'd700);
    send_beat(CMD_SWITCH, 15'd1, 15'h7fff, 64'd800);
    send_beat(CMD_SWITCH, 15'h7fff, 15'd1, 64'd900);
    send_beat(CMD_STOP,   15'd1, 15'd0, 64'd950);
    send_beat(CMD_STOP,   15'd0, 15'd0, 64'd960);
    send_beat(CMD_STOP,   15'd5, 15'h7fff, 64'd970);
    send_beat(CMD_START,  15'd0, 15'd0, 64'd980);
    send_beat(CMD_SWITCH, 15'd0, 15'd0, 64'hffff_ffff_ffff_ffff);
    // timestamp below the stamp: elapsed time wraps
    send_beat(CMD_SWITCH, 15'h7fff, 15'd0, 64'd5);
    send_beat(CMD_NONE,   15'h7fff, 15'h7fff, 64'hffff_ffff_ffff_ffff);
    send_beat(CMD_STOP,   15'h7fff, 15'd0, 64'd10);
    send_beat(CMD_STOP,   15'd1, 15'd0, 64'd20);
    send_beat(CMD_STOP,   15'd0, 15'd0, 64'd30);
    // freed slots keep id 0 but must not match
    send_beat(CMD_SWITCH, 15'd0, 15'd0, 64'd0);
    now = 64'd1000;

    run_phase( 0,  0, 45, 20, 1'b1);
    run_phase(79,  0, 20, 40, 1'b0);
    run_phase( 0, 79, 35, 35, 1'b0);
    run_phase(25, 25, 30, 30, 1'b0);

    in_ch.valid <= 1'b0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("task_runtime_accounting_table_top regression: pass");
    end else begin
      $display("task_runtime_accounting_table_top regression: fail");
    end
    $finish;
  end

endmodule
